// ===== src/nsc_pkg.sv =====
// ============================================================================
// nsc_pkg
// Shared types and constants for the non-overlapping substring counter.
// ============================================================================
`default_nettype none

package nsc_pkg;

    localparam int PATTERN_MAX_DEF = 8;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int WINDOW_DEPTH    = 8;
    localparam int GAP_WIDTH       = 4;
    localparam int POS_WIDTH       = 16;
    localparam int FIELD_WIDTH     = 16;
    localparam int CFG_LEN_WIDTH   = 4;
    localparam int CFG_DATA_WIDTH  = 64;
    localparam int CFG_INDEX_WIDTH = 1;

    localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_PATTERN_BYTES  = 1'b0,
        REG_PATTERN_LENGTH = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic                   match_ends_here;
        logic [FIELD_WIDTH-1:0] match_count;
        logic                   found;
        logic [FIELD_WIDTH-1:0] first_match_position;
        logic                   string_done;
    } t_out_word;

    typedef struct packed {
        logic step;
        logic last;
    } t_step_ctl;

endpackage

`default_nettype wire

// ===== src/nsc_match.sv =====
// ============================================================================
// nsc_match
// Parallel compare of the byte window against the pattern for every length.
// ============================================================================
`default_nettype none

module nsc_match
    import nsc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
    input  wire logic [PATTERN_MAX-1:0][7:0]   i_window,
    input  wire logic [CFG_DATA_WIDTH-1:0]     i_pattern,
    input  wire logic [LEN_W-1:0]              i_len,
    output logic                               o_equal
);

    logic [PATTERN_MAX-1:0] cand;

    // cand[L-1]: newest L bytes equal the first L pattern bytes
    always_comb begin
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            cand[l-1] = 1'b1;
            for (int k = 0; k < l; k++) begin
                if (i_window[l-1-k] != i_pattern[8*k +: 8]) begin
                    cand[l-1] = 1'b0;
                end
            end
        end
    end

    always_comb begin
        o_equal = 1'b0;
        for (int l = 1; l <= PATTERN_MAX; l++) begin
            if (i_len == LEN_W'(l)) begin
                o_equal = cand[l-1];
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/nsc_tracker.sv =====
// ============================================================================
// nsc_tracker
// Per-string state: byte window, gap since last match, count and positions.
// ============================================================================
`default_nettype none

module nsc_tracker
    import nsc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t_step_ctl                  i_ctl,
    input  wire logic [7:0]                 i_byte,
    input  wire logic [CFG_DATA_WIDTH-1:0]  i_pattern,
    input  wire logic [CFG_LEN_WIDTH-1:0]   i_length,
    output t_out_word                       o_result
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

    logic [PATTERN_MAX-1:0][7:0] r_win, n_win;
    logic [GAP_WIDTH-1:0]        r_gap, n_gap;
    logic [COUNT_WIDTH-1:0]      r_count, n_count;
    logic [POS_WIDTH-1:0]        r_pos, n_pos;
    logic [POS_WIDTH-1:0]        r_first, n_first;
    logic                        r_found, n_found;

    logic [LEN_W-1:0]            len;
    logic [GAP_WIDTH-1:0]        gap;
    logic [POS_WIDTH:0]          pos_inc;
    logic                        qual;
    logic                        equal;
    logic                        hit;
    logic [COUNT_WIDTH+FIELD_WIDTH-1:0] count_ext;

    always_comb begin
        if (i_length > CFG_LEN_WIDTH'(PATTERN_MAX)) begin
            len = LEN_W'(PATTERN_MAX);
        end else begin
            len = LEN_W'(i_length);
        end
    end

    always_comb begin
        n_win[0] = i_byte;
        for (int j = 1; j < PATTERN_MAX; j++) begin
            n_win[j] = r_win[j-1];
        end
    end

    nsc_match #(
        .PATTERN_MAX (PATTERN_MAX),
        .LEN_W       (LEN_W)
    ) u_match (
        .i_window  (n_win),
        .i_pattern (i_pattern),
        .i_len     (len),
        .o_equal   (equal)
    );

    always_comb begin
        if (r_gap >= GAP_WIDTH'(WINDOW_DEPTH)) begin
            gap = GAP_WIDTH'(WINDOW_DEPTH);
        end else begin
            gap = r_gap + 1'b1;
        end
        pos_inc = {1'b0, r_pos} + 1'b1;
        qual    = (len != '0) && (gap >= GAP_WIDTH'(len))
                  && (pos_inc >= (POS_WIDTH+1)'(len));
        hit     = qual && equal;
    end

    always_comb begin
        n_gap   = hit ? '0 : gap;
        n_count = r_count;
        n_found = r_found;
        n_first = r_first;
        if (hit) begin
            if (r_count != COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
            if (!r_found) begin
                n_found = 1'b1;
                if (r_pos == POS_MAX) begin
                    n_first = POS_MAX;
                end else begin
                    n_first = POS_WIDTH'(pos_inc - (POS_WIDTH+1)'(len));
                end
            end
        end
        n_pos = (r_pos == POS_MAX) ? r_pos : pos_inc[POS_WIDTH-1:0];
    end

    assign count_ext = {{FIELD_WIDTH{1'b0}}, n_count};

    always_comb begin
        o_result.match_ends_here      = hit;
        o_result.match_count          = count_ext[FIELD_WIDTH-1:0];
        o_result.found                = n_found;
        o_result.first_match_position = n_found ? n_first : '0;
        o_result.string_done          = i_ctl.last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win   <= '0;
            r_gap   <= GAP_WIDTH'(WINDOW_DEPTH);
            r_count <= '0;
            r_pos   <= '0;
            r_first <= '0;
            r_found <= 1'b0;
        end else if (i_ctl.step) begin
            if (i_ctl.last) begin
                r_win   <= '0;
                r_gap   <= GAP_WIDTH'(WINDOW_DEPTH);
                r_count <= '0;
                r_pos   <= '0;
                r_first <= '0;
                r_found <= 1'b0;
            end else begin
                r_win   <= n_win;
                r_gap   <= n_gap;
                r_count <= n_count;
                r_pos   <= n_pos;
                r_first <= n_first;
                r_found <= n_found;
            end
        end
    end

    a_found_tracks_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found == (r_count != '0))
        else $error("found flag disagrees with match count");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && i_ctl.last) |=>
            (r_count == '0 && r_pos == '0 && !r_found
             && r_gap == GAP_WIDTH'(WINDOW_DEPTH)))
        else $error("string state not cleared after last byte");

    a_gap_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.step && !i_ctl.last && hit) |=> (r_gap == '0 && r_found))
        else $error("gap not restarted after counted match");

endmodule

`default_nettype wire

// ===== src/nonoverlapping_substring_counter_unit.sv =====
// An accepted word is held in the stage-1 register; its result is then registered in r_out_word.
// Throughput: one byte per cycle unless the output stalls; the window compare is combinational.
// The input register advances with the output register or when empty; an output stall reaches o_in_stall same cycle.
// Reset (i_rst_n low, synchronous) clears pattern registers and all string state.
// String state also returns to reset values after the word carrying last_byte.
// ============================================================================
// nonoverlapping_substring_counter_unit
// Counts leftmost non-overlapping pattern matches in a byte stream.
// ============================================================================
`default_nettype none

module nonoverlapping_substring_counter_unit
    import nsc_pkg::*;
#(
    parameter int PATTERN_MAX = PATTERN_MAX_DEF,
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire t_in_word                    i_in_word,

    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output t_out_word                        o_out_word,

    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    logic [CFG_DATA_WIDTH-1:0] r_pattern_bytes;
    logic [CFG_LEN_WIDTH-1:0]  r_pattern_length;

    logic      r_s1_valid;
    t_in_word  r_s1_word;
    logic      r_out_valid;
    t_out_word r_out_word;

    logic      adv_out;
    logic      adv_in;
    t_step_ctl ctl;
    t_out_word result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_bytes  <= '0;
            r_pattern_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_PATTERN_BYTES:  r_pattern_bytes  <= i_cfg_data;
                REG_PATTERN_LENGTH: r_pattern_length <= i_cfg_data[CFG_LEN_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    assign adv_out    = !r_out_valid || !i_out_stall;
    assign adv_in     = !r_s1_valid || adv_out;
    assign o_in_stall = !adv_in;

    assign ctl.step = r_s1_valid && adv_out;
    assign ctl.last = r_s1_word.last_byte;

    nsc_tracker #(
        .PATTERN_MAX (PATTERN_MAX),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_byte    (r_s1_word.data_byte),
        .i_pattern (r_pattern_bytes),
        .i_length  (r_pattern_length),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv_in) begin
                r_s1_valid <= i_in_valid;
            end
            if (adv_out) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && i_in_valid) begin
            r_s1_word <= i_in_word;
        end
        if (ctl.step) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ============================================================================
// tb
// Self-checking bench for the non-overlapping substring counter. A directed
// table covers the corner cases, then random patterns and strings built
// mostly from pattern bytes. Result words are checked against a behavioral
// predictor or table values. Both sides insert random idles and stalls.
// ============================================================================

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import nsc_pkg::*;

    localparam int RANDOM_BYTES = 2000;
    localparam int PHASE_BYTES  = 170;
    localparam int N_ROWS       = 16;

    typedef struct packed {
        bit         cfg;
        bit [63:0]  pat;
        bit [3:0]   len;
        bit [7:0]   data;
        bit         last;
        bit [31:0]  reps;
        bit         typed;
        t_out_word  res;
    } stim_row_t;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    t_in_word                   i_in_word;
    logic                       o_out_valid;
    logic                       i_out_stall;
    t_out_word                  o_out_word;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    nonoverlapping_substring_counter_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predictor state
    bit [63:0]  pat_q;
    bit [3:0]   len_q;
    bit [7:0]   win_q [WINDOW_DEPTH];
    int         since_match;
    int         hit_count;
    int         pos_q;
    int         first_pos;
    bit         found_q;

    t_out_word  want_q [$];
    bit         calm;
    int         bad;
    int         results_seen;
    int         bytes_sent;
    int         strings_sent;
    int         patterns_used;
    int         stall_left;

    function automatic t_out_word res(bit m, int cnt, bit f, int fp, bit d);
        t_out_word r;
        r.match_ends_here      = m;
        r.match_count          = cnt[FIELD_WIDTH-1:0];
        r.found                = f;
        r.first_match_position = fp[FIELD_WIDTH-1:0];
        r.string_done          = d;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(bit [63:0] pat, bit [3:0] len);
        stim_row_t r;
        r     = '0;
        r.cfg = 1'b1;
        r.pat = pat;
        r.len = len;
        return r;
    endfunction

    function automatic stim_row_t byte_row(bit [7:0] data, bit last, int reps,
                                           bit typed, t_out_word r_exp);
        stim_row_t r;
        r       = '0;
        r.data  = data;
        r.last  = last;
        r.reps  = reps;
        r.typed = typed;
        r.res   = r_exp;
        return r;
    endfunction

    stim_row_t rows [N_ROWS] = '{
        byte_row(8'hFF, 1'b1, 1, 1'b1, res(0, 0, 0, 0, 1)),
        byte_row(8'h00, 1'b1, 1, 1'b1, res(0, 0, 0, 0, 1)),
        cfg_row(64'h6161, 4'd2),
        byte_row(8'h61, 1'b0, 3, 1'b0, '0),
        byte_row(8'h61, 1'b1, 1, 1'b1, res(1, 2, 1, 0, 1)),
        byte_row(8'h61, 1'b1, 1, 1'b1, res(0, 0, 0, 0, 1)),
        cfg_row(64'h0, 4'd8),
        byte_row(8'h00, 1'b1, 7, 1'b1, res(0, 0, 0, 0, 1)),
        byte_row(8'h00, 1'b1, 8, 1'b1, res(1, 1, 1, 0, 1)),
        cfg_row({64{1'b1}}, 4'd15),
        byte_row(8'hFF, 1'b0, 7, 1'b0, '0),
        byte_row(8'hFF, 1'b1, 1, 1'b1, res(1, 1, 1, 0, 1)),
        cfg_row(64'h41, 4'd0),
        byte_row(8'h41, 1'b1, 4, 1'b1, res(0, 0, 0, 0, 1)),
        cfg_row(64'h5A, 4'd1),
        byte_row(8'h5A, 1'b1, 1, 1'b1, res(1, 1, 1, 0, 1))
    };

    function automatic void clear_string();
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            win_q[i] = 8'h00;
        end
        since_match = WINDOW_DEPTH;
        hit_count   = 0;
        pos_q       = 0;
        first_pos   = 0;
        found_q     = 1'b0;
    endfunction

    function automatic t_out_word count_step(t_in_word w);
        int        len;
        int        gap;
        bit        hit;
        t_out_word r;
        len = (len_q > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len_q;
        for (int i = WINDOW_DEPTH - 1; i > 0; i--) begin
            win_q[i] = win_q[i-1];
        end
        win_q[0] = w.data_byte;
        gap = (since_match + 1 > WINDOW_DEPTH) ? WINDOW_DEPTH : since_match + 1;
        hit = (len > 0) && (gap >= len) && (pos_q + 1 >= len);
        for (int k = 0; k < len; k++) begin
            if (win_q[len-1-k] != pat_q[8*k +: 8]) begin
                hit = 1'b0;
            end
        end
        if (hit) begin
            since_match = 0;
            if (hit_count < (1 << COUNT_WIDTH_DEF) - 1) begin
                hit_count++;
            end
            if (!found_q) begin
                found_q   = 1'b1;
                first_pos = (pos_q >= int'(POS_MAX)) ? int'(POS_MAX) : pos_q + 1 - len;
            end
        end else begin
            since_match = gap;
        end
        if (pos_q < int'(POS_MAX)) begin
            pos_q++;
        end
        r = res(hit, hit_count, found_q, found_q ? first_pos : 0, w.last_byte);
        if (w.last_byte) begin
            clear_string();
        end
        return r;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    always #10 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        if (calm) begin
            stall_left  = 0;
            i_out_stall = 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else begin
            stall_left  = idle_len();
            i_out_stall = (stall_left > 0);
            if (stall_left > 0) begin
                stall_left--;
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_word w;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (want_q.size() == 0) begin
                bad++;
                if (bad <= 10) begin
                    $display("unexpected result word %0d: %p", results_seen, o_out_word);
                end
            end else begin
                w = want_q.pop_front();
                if (o_out_word.match_ends_here !== w.match_ends_here
                    || o_out_word.match_count !== w.match_count
                    || o_out_word.found !== w.found
                    || o_out_word.first_match_position !== w.first_match_position
                    || o_out_word.string_done !== w.string_done) begin
                    bad++;
                    if (bad <= 10) begin
                        $display("mismatch word %0d: exp hit=%0b cnt=%0d found=%0b first=%0d done=%0b",
                                 results_seen, w.match_ends_here, w.match_count, w.found,
                                 w.first_match_position, w.string_done);
                        $display("                   got hit=%0b cnt=%0d found=%0b first=%0d done=%0b",
                                 o_out_word.match_ends_here, o_out_word.match_count,
                                 o_out_word.found, o_out_word.first_match_position,
                                 o_out_word.string_done);
                    end
                end
            end
        end
    end

    task automatic feed_byte(t_in_word w, bit typed, t_out_word r_exp);
        int        gap;
        t_out_word r;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  = w;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        r = count_step(w);
        want_q.push_back(typed ? r_exp : r);
        bytes_sent++;
        if (w.last_byte) begin
            strings_sent++;
        end
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, bit [63:0] d);
        i_cfg_index = idx;
        i_cfg_data  = d;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == REG_PATTERN_BYTES) begin
            pat_q = d;
        end else begin
            len_q = d[3:0];
        end
        @(negedge i_clk);
    endtask

    task automatic set_pattern(bit [63:0] pat, bit [3:0] len);
        i_in_valid = 1'b0;
        while (want_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        write_reg(REG_PATTERN_BYTES, pat);
        write_reg(REG_PATTERN_LENGTH,
                  {$urandom, 15'($urandom_range(0, 15'h7FFF)), 13'h0, 4'h0} | 64'(len));
        i_cfg_valid = 1'b0;
        patterns_used++;
    endtask

    initial begin
        #40ms;
        $display("timeout with %0d result words outstanding", want_q.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        t_in_word  w;
        bit [63:0] pat;
        bit [3:0]  len;
        bit        two_letter;
        int        elen;
        int        cur;
        int        slen;
        int        r;
        int        phase;
        int        waited;

        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_word    = '0;
        i_out_stall  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = REG_PATTERN_BYTES;
        i_cfg_data   = '0;
        calm         = 1'b0;
        bad          = 0;
        results_seen = 0;
        bytes_sent   = 0;
        strings_sent = 0;
        patterns_used = 0;
        stall_left   = 0;
        pat_q        = '0;
        len_q        = '0;
        clear_string();

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (rows[i]) begin
            if (rows[i].cfg) begin
                set_pattern(rows[i].pat, rows[i].len);
            end else begin
                calm = (rows[i].reps > 64);
                for (int n = 0; n < rows[i].reps; n++) begin
                    w.data_byte = rows[i].data;
                    w.last_byte = rows[i].last && (n == rows[i].reps - 1);
                    feed_byte(w, rows[i].typed && (n == rows[i].reps - 1), rows[i].res);
                end
                calm = 1'b0;
            end
        end

        phase = 0;
        while (phase * PHASE_BYTES < RANDOM_BYTES) begin
            two_letter = $urandom_range(0, 1);
            for (int k = 0; k < 8; k++) begin
                pat[8*k +: 8] = two_letter ? ($urandom_range(0, 1) ? 8'h61 : 8'h62)
                                           : 8'($urandom_range(0, 255));
            end
            case (phase)
                0: len = 4'd8;
                1: len = 4'd15;
                2: len = 4'd0;
                default: len = ($urandom_range(0, 5) == 0) ? 4'($urandom_range(9, 15))
                                                           : 4'($urandom_range(1, 8));
            endcase
            set_pattern(pat, len);
            elen = (len > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : len;
            r    = bytes_sent + PHASE_BYTES;
            while (bytes_sent < r) begin
                calm = ($urandom_range(0, 3) == 0);
                slen = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60)
                                                   : $urandom_range(1, 24);
                cur  = 0;
                for (int n = 0; n < slen; n++) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2: begin
                            w.data_byte = 8'($urandom_range(0, 255));
                            cur = 0;
                        end
                        3, 4, 5, 6: w.data_byte = pat[8*$urandom_range(0, 7) +: 8];
                        default: begin
                            if (elen == 0) begin
                                w.data_byte = pat[7:0];
                            end else begin
                                w.data_byte = pat[8*cur +: 8];
                                cur = (cur + 1) % elen;
                            end
                        end
                    endcase
                    w.last_byte = (n == slen - 1);
                    feed_byte(w, 1'b0, '0);
                end
                calm = 1'b0;
            end
            phase++;
        end

        i_in_valid = 1'b0;
        waited     = 0;
        while (want_q.size() != 0 && waited < 20000) begin
            @(negedge i_clk);
            waited++;
        end
        if (want_q.size() != 0) begin
            $display("%0d expected result words never arrived", want_q.size());
            bad += want_q.size();
        end
        repeat (4) @(negedge i_clk);

        $display("covered %0d bytes in %0d strings under %0d pattern settings",
                 bytes_sent, strings_sent, patterns_used);
        $display("checked %0d result words, %0d failures", results_seen, bad);
        if (bad == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
